[design/x86br_pkg.sv]
package x86br_pkg;

  // request kinds
  typedef enum logic [3:0] {
    REQ_JCXZ      = 4'd0,
    REQ_JCC_SHORT = 4'd1,
    REQ_JMP_SHORT = 4'd2,
    REQ_JMP_REL16 = 4'd3,
    REQ_JMP_FAR   = 4'd4,
    REQ_JMP_ABS   = 4'd5,
    REQ_CALL_REL  = 4'd6,
    REQ_CALL_FAR  = 4'd7,
    REQ_CALL_ABS  = 4'd8,
    REQ_RET       = 4'd9,
    REQ_RET_IMM   = 4'd10,
    REQ_RETF      = 4'd11,
    REQ_RETF_IMM  = 4'd12
  } req_type_t;

  // jcc condition pairs, cond_code[3:1]; bit 0 inverts
  typedef enum logic [2:0] {
    COND_O  = 3'd0,
    COND_C  = 3'd1,
    COND_Z  = 3'd2,
    COND_NA = 3'd3,
    COND_S  = 3'd4,
    COND_P  = 3'd5,
    COND_L  = 3'd6,
    COND_NG = 3'd7
  } cond_pair_t;

  // flag bit positions
  localparam int unsigned FLAG_CF = 0;
  localparam int unsigned FLAG_PF = 1;
  localparam int unsigned FLAG_ZF = 2;
  localparam int unsigned FLAG_SF = 3;
  localparam int unsigned FLAG_OF = 4;

  localparam logic [15:0] SP_NEAR_PUSH = 16'hFFFE;
  localparam logic [15:0] SP_FAR_PUSH  = 16'hFFFC;
  localparam logic [15:0] SP_NEAR_POP  = 16'd2;
  localparam logic [15:0] SP_FAR_POP   = 16'd4;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [3:0]  cond_code;
    logic [4:0]  flag_bits;
    logic [15:0] count_reg;
    logic [15:0] next_ip;
    logic [15:0] code_seg;
    logic [15:0] stack_ptr;
    logic [15:0] immediate;
    logic [15:0] target_offset;
    logic [15:0] target_segment;
    logic [15:0] popped_offset;
    logic [15:0] popped_segment;
  } in_item_t;

  typedef struct packed {
    logic        taken;
    logic [15:0] new_ip;
    logic [15:0] new_cs;
    logic [15:0] new_sp;
    logic [1:0]  push_count;
    logic [15:0] push_first;
    logic [15:0] push_second;
  } out_item_t;

  // decoded item between the decode stage and the adder stage
  typedef struct packed {
    logic        taken;
    logic [15:0] ip_base;
    logic [15:0] ip_addend;
    logic [15:0] sp_base;
    logic [15:0] sp_addend;
    logic [15:0] new_cs;
    logic [1:0]  push_count;
    logic [15:0] push_first;
    logic [15:0] push_second;
  } dec_item_t;

  function automatic logic jcc_taken(logic [3:0] code, logic [4:0] flags);
    logic cf, pf, zf, sf, of_f, base;
    cf   = flags[FLAG_CF];
    pf   = flags[FLAG_PF];
    zf   = flags[FLAG_ZF];
    sf   = flags[FLAG_SF];
    of_f = flags[FLAG_OF];
    case (cond_pair_t'(code[3:1]))
      COND_O:  base = of_f;
      COND_C:  base = cf;
      COND_Z:  base = zf;
      COND_NA: base = cf | zf;
      COND_S:  base = sf;
      COND_P:  base = pf;
      COND_L:  base = sf ^ of_f;
      COND_NG: base = (sf ^ of_f) | zf;
      default: base = 1'b0;
    endcase
    return code[0] ? ~base : base;
  endfunction

endpackage

[design/x86_16bit_branch_resolver.sv]
// 8086 control-transfer resolver: takes one jump, call or return per item
// (jcxz, the sixteen jcc conditions, short/near/far jmp and call, ret and
// retf with or without a stack adjustment) and returns taken, the new
// ip:cs and sp, and the words a call must push (cs first for far calls).
// Short forms use only the low byte of the immediate, sign-extended, and
// all 16-bit sums wrap. Unused request codes 13 to 15 resolve as untaken
// with ip, cs and sp unchanged. Operand fetch and memory/stack traffic are
// done by the caller; popped words come in with the item.
// Timing: one item per cycle sustained while out_stall is low; an item
// passes through decode, 16-bit add and output register to out_valid. Each
// stage holds its item while the stage after it is full and stalled, so
// out_stall backs up through the pipe and in_stall rises only when all
// three stages are occupied.
module x86_16bit_branch_resolver (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  x86br_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output x86br_pkg::out_item_t out_data
);
  import x86br_pkg::*;

  // pipeline registers
  logic      s1_valid_r, s2_valid_r, out_valid_r;
  dec_item_t s1_data_r;
  out_item_t s2_data_r, out_data_r;

  logic      s1_valid_nxt, s2_valid_nxt, out_valid_nxt;
  dec_item_t s1_data_nxt;
  out_item_t s2_data_nxt;

  // stage load enables, a stage may load when empty or when it drains
  logic out_load, s2_load, s1_load;

  assign out_load = !out_valid_r || !out_stall;
  assign s2_load  = !s2_valid_r || out_load;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_stall = !s1_load;

  // ---------------------------------------------------------------------
  // stage 1: decode, condition test, operand selection
  // ---------------------------------------------------------------------
  logic [15:0] rel8;

  assign rel8 = {{8{in_data.immediate[7]}}, in_data.immediate[7:0]};

  always_comb begin
    s1_data_nxt             = '0;
    s1_data_nxt.taken       = 1'b1;
    s1_data_nxt.ip_base     = in_data.next_ip;
    s1_data_nxt.ip_addend   = '0;
    s1_data_nxt.sp_base     = in_data.stack_ptr;
    s1_data_nxt.sp_addend   = '0;
    s1_data_nxt.new_cs      = in_data.code_seg;
    case (req_type_t'(in_data.req_type))
      REQ_JCXZ: begin
        s1_data_nxt.taken     = (in_data.count_reg == '0);
        s1_data_nxt.ip_addend = s1_data_nxt.taken ? rel8 : '0;
      end
      REQ_JCC_SHORT: begin
        s1_data_nxt.taken     = jcc_taken(in_data.cond_code, in_data.flag_bits);
        s1_data_nxt.ip_addend = s1_data_nxt.taken ? rel8 : '0;
      end
      REQ_JMP_SHORT: s1_data_nxt.ip_addend = rel8;
      REQ_JMP_REL16: s1_data_nxt.ip_addend = in_data.immediate;
      REQ_JMP_FAR: begin
        s1_data_nxt.ip_base = in_data.target_offset;
        s1_data_nxt.new_cs  = in_data.target_segment;
      end
      REQ_JMP_ABS: s1_data_nxt.ip_base = in_data.target_offset;
      REQ_CALL_REL: begin
        s1_data_nxt.ip_addend  = in_data.immediate;
        s1_data_nxt.sp_addend  = SP_NEAR_PUSH;
        s1_data_nxt.push_count = 2'd1;
        s1_data_nxt.push_first = in_data.next_ip;
      end
      REQ_CALL_FAR: begin
        s1_data_nxt.ip_base     = in_data.target_offset;
        s1_data_nxt.new_cs      = in_data.target_segment;
        s1_data_nxt.sp_addend   = SP_FAR_PUSH;
        s1_data_nxt.push_count  = 2'd2;
        s1_data_nxt.push_first  = in_data.code_seg;
        s1_data_nxt.push_second = in_data.next_ip;
      end
      REQ_CALL_ABS: begin
        s1_data_nxt.ip_base    = in_data.target_offset;
        s1_data_nxt.sp_addend  = SP_NEAR_PUSH;
        s1_data_nxt.push_count = 2'd1;
        s1_data_nxt.push_first = in_data.next_ip;
      end
      REQ_RET: begin
        s1_data_nxt.ip_base   = in_data.popped_offset;
        s1_data_nxt.sp_addend = SP_NEAR_POP;
      end
      REQ_RET_IMM: begin
        s1_data_nxt.ip_base   = in_data.popped_offset;
        s1_data_nxt.sp_addend = in_data.immediate + SP_NEAR_POP;
      end
      REQ_RETF: begin
        s1_data_nxt.ip_base   = in_data.popped_offset;
        s1_data_nxt.new_cs    = in_data.popped_segment;
        s1_data_nxt.sp_addend = SP_FAR_POP;
      end
      REQ_RETF_IMM: begin
        s1_data_nxt.ip_base   = in_data.popped_offset;
        s1_data_nxt.new_cs    = in_data.popped_segment;
        s1_data_nxt.sp_addend = in_data.immediate + SP_FAR_POP;
      end
      default: s1_data_nxt.taken = 1'b0;  // unused codes: no-op
    endcase
  end

  assign s1_valid_nxt = s1_load ? in_valid : s1_valid_r;

  // ---------------------------------------------------------------------
  // stage 2: ip and sp adders, wrap at 16 bits
  // ---------------------------------------------------------------------
  always_comb begin
    s2_data_nxt.taken       = s1_data_r.taken;
    s2_data_nxt.new_ip      = s1_data_r.ip_base + s1_data_r.ip_addend;
    s2_data_nxt.new_cs      = s1_data_r.new_cs;
    s2_data_nxt.new_sp      = s1_data_r.sp_base + s1_data_r.sp_addend;
    s2_data_nxt.push_count  = s1_data_r.push_count;
    s2_data_nxt.push_first  = s1_data_r.push_first;
    s2_data_nxt.push_second = s1_data_r.push_second;
  end

  assign s2_valid_nxt  = s2_load ? s1_valid_r : s2_valid_r;
  assign out_valid_nxt = out_load ? s2_valid_r : out_valid_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, loaded only when the stage takes a new item
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_data_r <= s1_data_nxt;
    end
    if (s2_load && s1_valid_r) begin
      s2_data_r <= s2_data_nxt;
    end
    if (out_load && s2_valid_r) begin
      out_data_r <= s2_data_r;
    end
  end

  // stage 3: output register
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // input backs up only when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && out_valid_r))
    else $error("in_stall with a free pipeline stage");

  // a held decode-stage item is never dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_load) |=> s1_valid_r)
    else $error("decode stage item lost while stalled");

  // an item with no pushes carries zero push words
  a_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.push_count == 2'd0)
      |-> (out_data.push_first == 16'd0 && out_data.push_second == 16'd0))
    else $error("push words set without pushes");
`endif

endmodule
